/* rtl/core/fixed_point_q24_8_alu_macros.svh */
// Assertion macros used by the ALU top module.
`ifndef FIXED_POINT_Q24_8_ALU_MACROS_SVH
`define FIXED_POINT_Q24_8_ALU_MACROS_SVH
`ifndef SYNTHESIS
`define FPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FPA_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FPA_ASSERT(lbl, prop, msg)
`define FPA_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

/* rtl/core/fpa_pkg.sv */
`default_nettype none
package fpa_pkg;

  localparam int unsigned FRAC_BITS_DEF = 8;
  localparam int unsigned WORD_W        = 32;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_GT   = 4'd4,
    OP_LT   = 4'd5,
    OP_GE   = 4'd6,
    OP_LE   = 4'd7,
    OP_EQ   = 4'd8,
    OP_NE   = 4'd9,
    OP_MIN  = 4'd10,
    OP_MAX  = 4'd11,
    OP_FINT = 4'd12,
    OP_TINT = 4'd13,
    OP_INC  = 4'd14,
    OP_DEC  = 4'd15
  } op_t;

  // Per-item control riding along the divider chain.
  typedef struct packed {
    logic valid;
    logic is_div;
    logic neg;
    logic cmp;
    logic dz;
  } ctl_t;

endpackage
`default_nettype wire

/* rtl/core/fixed_point_q24_8_alu.sv */
// Channel | Ports       | Item fields (lowest bit up)
// --------+-------------+----------------------------------------------
// input   | in_t*       | opcode[3:0], operand_a[35:4], operand_b[67:36]
// result  | out_t*      | result_value[31:0], compare_true[32], divide_by_zero[33]
//
// One item enters per cycle while the output does not stall; an item that is taken
// passes through one front stage, 32 + FRACTION_BITS divider cells and one output
// register before its result appears. Every opcode travels the full divider chain so order holds.
// A stalled output freezes the whole chain and drops in_tready in the same cycle.
// Reset (rst_n low, synchronous) clears the valid bits of every stage.
`default_nettype none
`include "fixed_point_q24_8_alu_macros.svh"
module fixed_point_q24_8_alu #(
  parameter int unsigned FRACTION_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // opcode, operand_a, operand_b, zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // result_value, compare_true, divide_by_zero, pad
);

  localparam int unsigned DW = fpa_pkg::WORD_W + FRACTION_BITS;

  logic adv;
  fpa_pkg::ctl_t ctl   [DW+1];
  logic [31:0]   res   [DW+1];
  logic [31:0]   rem   [DW+1];
  logic [DW-1:0] dq    [DW+1];
  logic [31:0]   dsr   [DW+1];
  logic [DW:0]   vld_vec;

  logic        out_valid_r;
  logic [31:0] out_res_r, out_res_nxt, qmag;
  logic        out_cmp_r, out_dz_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  fpa_front #(.FRAC(FRACTION_BITS), .DW(DW)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_valid(in_tvalid),
    .opcode  (in_tdata[3:0]),
    .opa     ($signed(in_tdata[35:4])),
    .opb     ($signed(in_tdata[67:36])),
    .ctl_o   (ctl[0]),
    .res_o   (res[0]),
    .dq_o    (dq[0]),
    .dsr_o   (dsr[0])
  );
  assign rem[0] = '0;

  for (genvar i = 0; i < DW; i++) begin : g_cell
    fpa_cell #(.DW(DW)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .adv  (adv),
      .ctl_i(ctl[i]),
      .res_i(res[i]),
      .rem_i(rem[i]),
      .dq_i (dq[i]),
      .dsr_i(dsr[i]),
      .ctl_o(ctl[i+1]),
      .res_o(res[i+1]),
      .rem_o(rem[i+1]),
      .dq_o (dq[i+1]),
      .dsr_o(dsr[i+1])
    );
  end

  for (genvar k = 0; k <= DW; k++) begin : g_vld
    assign vld_vec[k] = ctl[k].valid;
  end

  // Quotient low word; apply the sign after the unsigned divide.
  assign qmag        = dq[DW][31:0];
  assign out_res_nxt = ctl[DW].is_div ? (ctl[DW].neg ? (32'd0 - qmag) : qmag) : res[DW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl[DW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= out_res_nxt;
      out_cmp_r <= ctl[DW].cmp;
      out_dz_r  <= ctl[DW].dz;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_dz_r, out_cmp_r, out_res_r};

  `FPA_ASSERT(a_dz_zero, out_tvalid && out_dz_r |-> out_res_r == 32'd0 && !out_cmp_r, "div by zero result not clean")
  `FPA_ASSERT(a_cmp_zero, out_tvalid && out_cmp_r |-> out_res_r == 32'd0, "compare result not zero")
  `FPA_ASSERT(a_stall_hold, !adv |=> $stable(vld_vec), "chain moved while stalled")
  `FPA_ASSERT_NEVER(a_div_dz, ctl[DW].is_div && ctl[DW].dz, "divide and div-by-zero both set")

endmodule
`default_nettype wire

/* rtl/core/fpa_front.sv */
`default_nettype none
module fpa_front #(
  parameter int unsigned FRAC = fpa_pkg::FRAC_BITS_DEF,
  parameter int unsigned DW   = fpa_pkg::WORD_W + FRAC
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               in_valid,
  input  wire logic [3:0]         opcode,
  input  wire logic signed [31:0] opa,
  input  wire logic signed [31:0] opb,
  output fpa_pkg::ctl_t           ctl_o,
  output logic [31:0]             res_o,
  output logic [DW-1:0]           dq_o,
  output logic [31:0]             dsr_o
);

  fpa_pkg::ctl_t  ctl_r, ctl_nxt;
  logic [31:0]    res_r, res_nxt;
  logic [DW-1:0]  dq_r;
  logic [31:0]    dsr_r;
  logic signed [63:0] prod;
  logic [31:0]    a_abs, b_abs;
  logic           lt, gt, eq;

  assign prod  = 64'(opa) * 64'(opb);
  assign a_abs = opa[31] ? (32'd0 - 32'(opa)) : 32'(opa);
  assign b_abs = opb[31] ? (32'd0 - 32'(opb)) : 32'(opb);
  assign lt    = opa < opb;
  assign gt    = opa > opb;
  assign eq    = opa == opb;

  always_comb begin
    ctl_nxt        = '0;
    ctl_nxt.valid  = in_valid;
    ctl_nxt.neg    = opa[31] ^ opb[31];
    res_nxt        = '0;
    case (fpa_pkg::op_t'(opcode))
      fpa_pkg::OP_ADD:  res_nxt = 32'(opa + opb);
      fpa_pkg::OP_SUB:  res_nxt = 32'(opa - opb);
      fpa_pkg::OP_MUL:  res_nxt = prod[FRAC+31:FRAC];
      fpa_pkg::OP_DIV: begin
        if (opb == 32'sd0) ctl_nxt.dz = 1'b1;
        else ctl_nxt.is_div = 1'b1;
      end
      fpa_pkg::OP_GT:   ctl_nxt.cmp = gt;
      fpa_pkg::OP_LT:   ctl_nxt.cmp = lt;
      fpa_pkg::OP_GE:   ctl_nxt.cmp = !lt;
      fpa_pkg::OP_LE:   ctl_nxt.cmp = !gt;
      fpa_pkg::OP_EQ:   ctl_nxt.cmp = eq;
      fpa_pkg::OP_NE:   ctl_nxt.cmp = !eq;
      fpa_pkg::OP_MIN:  res_nxt = lt ? 32'(opa) : 32'(opb);
      fpa_pkg::OP_MAX:  res_nxt = gt ? 32'(opa) : 32'(opb);
      fpa_pkg::OP_FINT: res_nxt = {opa[31-FRAC:0], {FRAC{1'b0}}};
      fpa_pkg::OP_TINT: res_nxt = 32'(opa >>> FRAC);
      fpa_pkg::OP_INC:  res_nxt = 32'(opa + 32'sd1);
      fpa_pkg::OP_DEC:  res_nxt = 32'(opa - 32'sd1);
      default:          res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
      dq_r  <= {a_abs, {FRAC{1'b0}}};
      dsr_r <= b_abs;
    end
  end

  assign ctl_o = ctl_r;
  assign res_o = res_r;
  assign dq_o  = dq_r;
  assign dsr_o = dsr_r;

endmodule
`default_nettype wire

/* rtl/core/fpa_cell.sv */
`default_nettype none
module fpa_cell #(
  parameter int unsigned DW = fpa_pkg::WORD_W + fpa_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  fpa_pkg::ctl_t      ctl_i,
  input  wire logic [31:0]   res_i,
  input  wire logic [31:0]   rem_i,
  input  wire logic [DW-1:0] dq_i,
  input  wire logic [31:0]   dsr_i,
  output fpa_pkg::ctl_t      ctl_o,
  output logic [31:0]        res_o,
  output logic [31:0]        rem_o,
  output logic [DW-1:0]      dq_o,
  output logic [31:0]        dsr_o
);

  fpa_pkg::ctl_t  ctl_r;
  logic [31:0]    res_r, rem_r, rem_nxt, dsr_r;
  logic [DW-1:0]  dq_r, dq_nxt;
  logic [32:0]    shifted;
  logic [33:0]    diff;
  logic           ge;

  // One restoring step: bring down the next dividend bit, trial subtract.
  assign shifted = {rem_i, dq_i[DW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_i};
  assign ge      = !diff[33];
  assign rem_nxt = ge ? diff[31:0] : shifted[31:0];
  assign dq_nxt  = {dq_i[DW-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_i;
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
      dsr_r <= dsr_i;
    end
  end

  assign ctl_o = ctl_r;
  assign res_o = res_r;
  assign rem_o = rem_r;
  assign dq_o  = dq_r;
  assign dsr_o = dsr_r;

endmodule
`default_nettype wire

/* sim/fixed_point_q24_8_alu_checker.sv */
`default_nettype none
module fixed_point_q24_8_alu_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [71:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata,
  output int               error_count,
  output int               pending_count,
  output int               result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = fpa_pkg::FRAC_BITS_DEF;

  typedef struct packed {
    logic        dz;
    logic        cmp;
    logic [31:0] value;
  } alu_result_t;

  alu_result_t awaited_results[$];

  function automatic alu_result_t compute_alu(fpa_pkg::op_t op, logic signed [31:0] a,
                                              logic signed [31:0] b);
    alu_result_t r;
    logic signed [63:0] prod;
    logic signed [63:0] num;
    r = '0;
    case (op)
      fpa_pkg::OP_ADD:  r.value = a + b;
      fpa_pkg::OP_SUB:  r.value = a - b;
      fpa_pkg::OP_MUL: begin
        prod = 64'(a) * 64'(b);
        r.value = 32'(prod >>> FRAC);
      end
      fpa_pkg::OP_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          num = 64'(a) <<< FRAC;
          r.value = 32'(num / 64'(b));
        end
      end
      fpa_pkg::OP_GT:   r.cmp = a > b;
      fpa_pkg::OP_LT:   r.cmp = a < b;
      fpa_pkg::OP_GE:   r.cmp = a >= b;
      fpa_pkg::OP_LE:   r.cmp = a <= b;
      fpa_pkg::OP_EQ:   r.cmp = a == b;
      fpa_pkg::OP_NE:   r.cmp = a != b;
      fpa_pkg::OP_MIN:  r.value = (a < b) ? a : b;
      fpa_pkg::OP_MAX:  r.value = (a > b) ? a : b;
      fpa_pkg::OP_FINT: r.value = a << FRAC;
      fpa_pkg::OP_TINT: r.value = a >>> FRAC;
      fpa_pkg::OP_INC:  r.value = a + 1;
      default:          r.value = a - 1;
    endcase
    return r;
  endfunction

  initial begin
    error_count = 0;
    result_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    alu_result_t got;
    alu_result_t want;
    if (rst_n && in_tvalid && in_tready) begin
      awaited_results.push_back(compute_alu(fpa_pkg::op_t'(in_tdata[3:0]), in_tdata[35:4],
                                            in_tdata[67:36]));
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[33:0];
      result_count++;
      if (awaited_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result item %h", $realtime, got);
      end else begin
        want = awaited_results.pop_front();
        if (got.value !== want.value) begin
          error_count++;
          $display("%0t: result_value expected %h actual %h", $realtime, want.value,
                   got.value);
        end
        if (got.cmp !== want.cmp) begin
          error_count++;
          $display("%0t: compare_true expected %b actual %b", $realtime, want.cmp, got.cmp);
        end
        if (got.dz !== want.dz) begin
          error_count++;
          $display("%0t: divide_by_zero expected %b actual %b", $realtime, want.dz, got.dz);
        end
      end
    end
    pending_count = awaited_results.size();
  end
endmodule
`default_nettype wire

/* sim/fixed_point_q24_8_alu_test.sv */
`default_nettype none
module fixed_point_q24_8_alu_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  int          error_count;
  int          pending_count;
  int          result_count;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          item_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fixed_point_q24_8_alu i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready, .out_tdata
  );

  fixed_point_q24_8_alu_checker i_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .error_count, .pending_count, .result_count
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Hold each item until taken; idle cycles between items at the chosen rate.
  task automatic send_op(fpa_pkg::op_t op, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, b, a, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    item_count++;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7fff_ffff - $urandom_range(3);
      2: return 32'($signed($urandom_range(2048)) - 1024);
      3: return $urandom_range(1) ? 32'h0 : 32'hffff_ff00;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int n, int idle_pct, int stall_pct);
    logic [31:0] a;
    logic [31:0] b;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (n) begin
      a = pick_operand();
      b = ($urandom_range(9) == 0) ? 32'h0 : pick_operand();
      if ($urandom_range(7) == 0) b = a;
      send_op(fpa_pkg::op_t'($urandom_range(15)), a, b);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_op(fpa_pkg::OP_ADD, 32'h7fff_ffff, 32'h1);
    send_op(fpa_pkg::OP_SUB, 32'h8000_0000, 32'h1);
    send_op(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send_op(fpa_pkg::OP_MUL, 32'hffff_ff80, 32'h0000_0180);
    send_op(fpa_pkg::OP_DIV, 32'h0000_0300, 32'h0);
    send_op(fpa_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_op(fpa_pkg::OP_DIV, 32'hffff_fd00, 32'h0000_0200);
    send_op(fpa_pkg::OP_GT, 32'h8000_0000, 32'h7fff_ffff);
    send_op(fpa_pkg::OP_LT, 32'h8000_0000, 32'h7fff_ffff);
    send_op(fpa_pkg::OP_GE, 32'h5, 32'h5);
    send_op(fpa_pkg::OP_LE, 32'h6, 32'h5);
    send_op(fpa_pkg::OP_EQ, 32'hffff_ffff, 32'hffff_ffff);
    send_op(fpa_pkg::OP_NE, 32'hffff_ffff, 32'hffff_ffff);
    send_op(fpa_pkg::OP_MIN, 32'h8000_0000, 32'h7fff_ffff);
    send_op(fpa_pkg::OP_MAX, 32'h8000_0000, 32'h7fff_ffff);
    send_op(fpa_pkg::OP_FINT, 32'h0080_0001, 32'hffff_ffff);
    send_op(fpa_pkg::OP_TINT, 32'hffff_ff01, 32'h0);
    send_op(fpa_pkg::OP_TINT, 32'h7fff_ffff, 32'h0);
    send_op(fpa_pkg::OP_INC, 32'h7fff_ffff, 32'h0);
    send_op(fpa_pkg::OP_DEC, 32'h8000_0000, 32'h0);
    random_phase(250, 0, 0);
    // drain completely before going on
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    random_phase(250, 74, 0);
    random_phase(250, 0, 74);
    random_phase(280, 35, 35);
    receiver_stall_pct = 0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d items over all 16 opcodes, operand extremes and zero divisors,",
             item_count);
    $display("with %0d results checked under idle and stall mixes", result_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("fixed_point_q24_8_alu_test: clean");
    end else begin
      $display("fixed_point_q24_8_alu_test: errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("fixed_point_q24_8_alu_test: errors");
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
+incdir+rtl/core
rtl/core/fpa_pkg.sv
rtl/core/fpa_front.sv
rtl/core/fpa_cell.sv
rtl/core/fixed_point_q24_8_alu.sv
sim/fixed_point_q24_8_alu_checker.sv
sim/fixed_point_q24_8_alu_test.sv
